// ===== src/pam_pkg.sv =====
// Shared types, constants and gain tables for the auto-ranging PGA measurement block.
// No dependencies; used by every module under src.
package pam_pkg;

    localparam int ADC_W    = 10;
    localparam int CUR_W    = 17;
    localparam int VALUE_W  = 26;
    localparam int GAIN_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Shared divider sizing: dividend magnitude and divisor width.
    localparam int DIV_N_W   = 32;
    localparam int DIV_D_W   = 27;
    localparam int DIV_CNT_W = $clog2(DIV_N_W);

    localparam logic [ADC_W-1:0]  OVER_LIMIT = 10'd1021;
    localparam logic [GAIN_W-1:0] GAIN_MAX   = 3'd7;
    localparam logic [7:0]        PGA_PREFIX = 8'h2A;

    // Voltage /100: drop two bits, then multiply by ceil(2^33/25) and keep bits 33 and up.
    // Exact for every quarter-magnitude below 2^30.
    localparam int               SCALE_Y_W   = 29;
    localparam int               SCALE_Q_W   = 25;
    localparam int               SCALE_SHIFT = 33;
    localparam logic [SCALE_Y_W-1:0] SCALE_RECIP = 29'd343597384;

    // Result status codes.
    localparam logic [1:0] STATUS_VALID    = 2'd0;
    localparam logic [1:0] STATUS_LOWERED  = 2'd1;
    localparam logic [1:0] STATUS_RAISED   = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_RATIO    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHUNT_RESISTANCE = 2'd1;

    typedef struct packed {
        logic [1:0]        status;
        logic [GAIN_W-1:0] new_gain;
        logic              compute;
    } range_t;

    function automatic logic [7:0] gain_of(input logic [GAIN_W-1:0] g);
        logic [7:0] r;
        case (g)
            3'd0:    r = 8'd1;
            3'd1:    r = 8'd2;
            3'd2:    r = 8'd5;
            3'd3:    r = 8'd10;
            3'd4:    r = 8'd20;
            3'd5:    r = 8'd50;
            3'd6:    r = 8'd100;
            default: r = 8'd200;
        endcase
        return r;
    endfunction

    // Gain times the fixed /10 of the current scaling.
    function automatic logic [10:0] gain10_of(input logic [GAIN_W-1:0] g);
        logic [10:0] r;
        case (g)
            3'd0:    r = 11'd10;
            3'd1:    r = 11'd20;
            3'd2:    r = 11'd50;
            3'd3:    r = 11'd100;
            3'd4:    r = 11'd200;
            3'd5:    r = 11'd500;
            3'd6:    r = 11'd1000;
            default: r = 11'd2000;
        endcase
        return r;
    endfunction

    function automatic logic [8:0] raise_thr(input logic [GAIN_W-1:0] g);
        logic [8:0] r;
        case (g)
            3'd0, 3'd3, 3'd6: r = 9'd480;
            3'd1, 3'd4:       r = 9'd170;
            3'd2, 3'd5:       r = 9'd70;
            default:          r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== src/pga_autorange_measurement.sv =====
// Auto-ranging two-channel PGA measurement. One sample is taken at a time: s_ready is high
// only while the sequencer is idle. A sample that changes the gain or overflows goes from
// ST_IDLE straight to ST_DONE; a current sample passes ST_MUL_A, ST_MUL_B, ST_DIV_GO and
// ST_DIV_WAIT, a voltage sample also ST_MUL_C, ST_SUB and ST_SCALE. s_ready returns in the
// cycle the result appears. The time is set by one 32-step pass of the shared divider
// (gain, and shunt for current) plus the multiply steps; a voltage sample adds the current
// subtraction and a reciprocal multiply for the final /100. A finished result waits in the
// output register while the next sample is accepted; a result that finds it still occupied
// holds the sequencer until m_ready. Depends on pam_pkg, pam_range and pam_divider.
module pga_autorange_measurement (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_func,
    input  logic [pam_pkg::ADC_W-1:0]           s_adc_sample,
    input  logic signed [pam_pkg::CUR_W-1:0]    s_current_ma,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_status,
    output logic signed [pam_pkg::VALUE_W-1:0]  m_value,
    output logic [pam_pkg::GAIN_W-1:0]          m_gain_index,
    output logic [7:0]                          m_pga_word,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pam_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pam_pkg::CFG_DATA_W-1:0]      cfg_data
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b0_0000_0001,
        ST_MUL_A    = 9'b0_0000_0010,
        ST_MUL_B    = 9'b0_0000_0100,
        ST_DIV_GO   = 9'b0_0000_1000,
        ST_DIV_WAIT = 9'b0_0001_0000,
        ST_MUL_C    = 9'b0_0010_0000,
        ST_SUB      = 9'b0_0100_0000,
        ST_SCALE    = 9'b0_1000_0000,
        ST_DONE     = 9'b1_0000_0000
    } state_t;

    localparam int GW = pam_pkg::GAIN_W;
    localparam int VW = pam_pkg::VALUE_W;
    localparam int NW = pam_pkg::DIV_N_W;
    localparam int DW = pam_pkg::DIV_D_W;
    localparam int YW = pam_pkg::SCALE_Y_W;
    localparam int QW = pam_pkg::SCALE_Q_W;

    state_t state_reg, state_next;

    logic [7:0]  div_ratio_reg, div_ratio_next;
    logic [15:0] shunt_reg, shunt_next;
    logic [GW-1:0] cur_gain_reg, cur_gain_next;
    logic [GW-1:0] volt_gain_reg, volt_gain_next;

    logic                func_reg, func_next;
    logic [pam_pkg::ADC_W-1:0] s_reg, s_next;
    logic signed [pam_pkg::CUR_W-1:0] cur_reg, cur_next;
    logic [GW-1:0]       g_reg, g_next;
    logic                neg_reg, neg_next;
    logic signed [32:0]  acc_reg, acc_next;
    logic signed [23:0]  tmp_reg, tmp_next;
    logic [DW-1:0]       dvs_reg, dvs_next;
    logic [1:0]          res_status_reg, res_status_next;
    logic signed [VW-1:0] res_value_reg, res_value_next;

    logic                m_valid_reg, m_valid_next;
    logic [1:0]          m_status_reg, m_status_next;
    logic signed [VW-1:0] m_value_reg, m_value_next;
    logic [GW-1:0]       m_gain_reg, m_gain_next;
    logic [7:0]          m_pga_reg, m_pga_next;

    pam_pkg::range_t     rng;
    logic [GW-1:0]       chan_gain;

    logic signed [11:0]  d;
    logic [15:0]         shunt_eff;
    logic signed [24:0]  mul_a;
    logic signed [16:0]  mul_b;
    logic signed [41:0]  prod;
    logic signed [32:0]  acc_neg;
    logic signed [32:0]  q_signed;

    logic [YW-1:0]       scale_y;
    logic [2*YW-1:0]     scale_prod;
    logic [QW-1:0]       scale_q;
    logic signed [VW-1:0] scale_val;

    logic                div_start;
    logic [NW-1:0]       div_dividend;
    logic                div_done;
    logic [NW-1:0]       div_quo;

    assign chan_gain = s_func ? volt_gain_reg : cur_gain_reg;

    pam_range u_range (
        .adc_sample (s_adc_sample),
        .gain       (chan_gain),
        .range      (rng)
    );

    pam_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (dvs_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign d         = $signed({1'b0, s_reg, 1'b0}) - 12'sd2;
    assign shunt_eff = (shunt_reg == '0) ? 16'd1 : shunt_reg;
    assign acc_neg   = -acc_reg;
    assign q_signed  = neg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    assign div_start = (state_reg == ST_DIV_GO);
    assign div_dividend = acc_reg[32] ? acc_neg[NW-1:0] : acc_reg[NW-1:0];

    // Magnitude below 2^31 here: divide by 4, then by 25 through the reciprocal.
    assign scale_y    = div_dividend[YW+1:2];
    assign scale_prod = scale_y * pam_pkg::SCALE_RECIP;
    assign scale_q    = scale_prod[pam_pkg::SCALE_SHIFT +: QW];
    assign scale_val  = acc_reg[32] ? -$signed({1'b0, scale_q}) : $signed({1'b0, scale_q});

    // Shared multiplier, operands chosen by the sequencer step.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL_A: begin
                mul_a = {{13{d[11]}}, d};
                mul_b = func_reg ? 17'sd100 : $signed({9'b0, div_ratio_reg});
            end
            ST_MUL_B: begin
                if (func_reg) begin
                    mul_a = $signed({17'b0, pam_pkg::gain_of(g_reg)});
                    mul_b = 17'sd1;
                end else begin
                    mul_a = $signed({14'b0, pam_pkg::gain10_of(g_reg)});
                    mul_b = $signed({1'b0, shunt_eff});
                end
            end
            ST_MUL_C: begin
                mul_a = {{8{cur_reg[16]}}, cur_reg};
                mul_b = 17'sd100;
            end
            ST_SUB: begin
                mul_a = acc_reg[24:0] - {tmp_reg[23], tmp_reg};
                mul_b = $signed({9'b0, div_ratio_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_comb begin
        state_next      = state_reg;
        div_ratio_next  = div_ratio_reg;
        shunt_next      = shunt_reg;
        cur_gain_next   = cur_gain_reg;
        volt_gain_next  = volt_gain_reg;
        func_next       = func_reg;
        s_next          = s_reg;
        cur_next        = cur_reg;
        g_next          = g_reg;
        neg_next        = neg_reg;
        acc_next        = acc_reg;
        tmp_next        = tmp_reg;
        dvs_next        = dvs_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_value_next    = m_value_reg;
        m_gain_next     = m_gain_reg;
        m_pga_next      = m_pga_reg;

        if (cfg_valid) begin
            case (cfg_index)
                pam_pkg::REG_DIVIDER_RATIO:    div_ratio_next = cfg_data[7:0];
                pam_pkg::REG_SHUNT_RESISTANCE: shunt_next     = cfg_data;
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    func_next       = s_func;
                    s_next          = s_adc_sample;
                    cur_next        = s_current_ma;
                    g_next          = rng.new_gain;
                    res_status_next = rng.status;
                    res_value_next  = '0;
                    if (s_func) begin
                        volt_gain_next = rng.new_gain;
                    end else begin
                        cur_gain_next  = rng.new_gain;
                    end
                    state_next = rng.compute ? ST_MUL_A : ST_DONE;
                end
            end
            ST_MUL_A: begin
                acc_next   = prod[32:0];
                state_next = ST_MUL_B;
            end
            ST_MUL_B: begin
                dvs_next   = prod[DW-1:0];
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                neg_next   = acc_reg[32];
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    if (!func_reg) begin
                        res_value_next = q_signed[VW-1:0];
                        state_next     = ST_DONE;
                    end else begin
                        acc_next   = q_signed;
                        state_next = ST_MUL_C;
                    end
                end
            end
            ST_MUL_C: begin
                tmp_next   = prod[23:0];
                state_next = ST_SUB;
            end
            ST_SUB: begin
                // subtract the current term, then scale by the divider ratio
                acc_next   = prod[32:0];
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                res_value_next = scale_val;
                state_next     = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_value_next  = res_value_reg;
                    m_gain_next   = g_reg;
                    m_pga_next    = {1'b0, g_reg, 3'b000, ~func_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            div_ratio_reg <= 8'd1;
            shunt_reg     <= 16'd1;
            cur_gain_reg  <= '0;
            volt_gain_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            div_ratio_reg <= div_ratio_next;
            shunt_reg     <= shunt_next;
            cur_gain_reg  <= cur_gain_next;
            volt_gain_reg <= volt_gain_next;
            m_valid_reg   <= m_valid_next;
        end
        func_reg       <= func_next;
        s_reg          <= s_next;
        cur_reg        <= cur_next;
        g_reg          <= g_next;
        neg_reg        <= neg_next;
        acc_reg        <= acc_next;
        tmp_reg        <= tmp_next;
        dvs_reg        <= dvs_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        m_status_reg   <= m_status_next;
        m_value_reg    <= m_value_next;
        m_gain_reg     <= m_gain_next;
        m_pga_reg      <= m_pga_next;
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_value      = m_value_reg;
    assign m_gain_index = m_gain_reg;
    assign m_pga_word   = m_pga_reg;

endmodule

// ===== src/pam_range.sv =====
// Range decision: picks lower/raise/overflow/compute from a sample and the stored gain.
// Depends on pam_pkg.
module pam_range (
    input  logic [pam_pkg::ADC_W-1:0]  adc_sample,
    input  logic [pam_pkg::GAIN_W-1:0] gain,
    output pam_pkg::range_t            range
);

    always_comb begin
        range.status   = pam_pkg::STATUS_VALID;
        range.new_gain = gain;
        range.compute  = 1'b0;
        if (adc_sample > pam_pkg::OVER_LIMIT) begin
            if (gain != '0) begin
                range.new_gain = gain - 3'd1;
                range.status   = pam_pkg::STATUS_LOWERED;
            end else begin
                range.status   = pam_pkg::STATUS_OVERFLOW;
            end
        end else if (adc_sample < {1'b0, pam_pkg::raise_thr(gain)}
                     && gain != pam_pkg::GAIN_MAX) begin
            range.new_gain = gain + 3'd1;
            range.status   = pam_pkg::STATUS_RAISED;
        end else begin
            range.compute  = 1'b1;
        end
    end

endmodule

// ===== src/pam_divider.sv =====
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on pam_pkg for operand widths.
module pam_divider (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [pam_pkg::DIV_N_W-1:0] dividend,
    input  logic [pam_pkg::DIV_D_W-1:0] divisor,
    output logic                        done,
    output logic [pam_pkg::DIV_N_W-1:0] quotient
);

    localparam int N = pam_pkg::DIV_N_W;
    localparam int D = pam_pkg::DIV_D_W;
    localparam int C = pam_pkg::DIV_CNT_W;

    logic [N-1:0] quo_reg, quo_next;
    logic [D-1:0] rem_reg, rem_next;
    logic [D-1:0] dvs_reg, dvs_next;
    logic [C-1:0] cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;

    logic [D:0] trial;
    logic [D:0] diff;
    logic       fits;

    assign trial = {rem_reg, quo_reg[N-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // shift in the next dividend bit, subtract when it fits
            rem_next = fits ? diff[D-1:0] : trial[D-1:0];
            quo_next = {quo_reg[N-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == C'(N - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/pam_checker.sv =====
// Port-level checks for pga_autorange_measurement, attached by the bind below.
// Depends on pam_pkg for status codes and field widths.
module pam_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [1:0]                         m_status,
    input logic signed [pam_pkg::VALUE_W-1:0] m_value,
    input logic [pam_pkg::GAIN_W-1:0]         m_gain_index,
    input logic [7:0]                         m_pga_word
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value) && $stable(m_status))
        else $error("result changed while stalled");

    // one sample in flight: no transfer in the cycle after one
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted back to back");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != pam_pkg::STATUS_VALID |-> m_value == '0)
        else $error("nonzero value with range status");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_pga_word[6:4] == m_gain_index && m_pga_word[7] == 1'b0
                    && m_pga_word[3:1] == 3'b000)
        else $error("PGA word does not match gain index");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == pam_pkg::STATUS_OVERFLOW |-> m_gain_index == '0)
        else $error("overflow reported above lowest gain");

endmodule

bind pga_autorange_measurement pam_checker u_pam_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_value      (m_value),
    .m_gain_index (m_gain_index),
    .m_pga_word   (m_pga_word)
);

// ===== dv/pga_autorange_measurement_test.sv =====
// Self-checking testbench for pga_autorange_measurement: random and directed samples on both
// channels, predicted in-line and checked against every result transfer.
// Depends on pam_pkg and the RTL under src.
module pga_autorange_measurement_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT = 3_000_000;
    localparam int          SETTLE      = 100;
    localparam int          RX_STALL    = 2500;
    localparam int          MAX_REPORTS = 10;
    // Index 3 decodes to no register; writes there must change nothing.
    localparam logic [pam_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic                             func;
        logic [pam_pkg::ADC_W-1:0]        sample;
        logic signed [pam_pkg::CUR_W-1:0] current;
    } sample_t;

    typedef struct packed {
        logic [1:0]                         status;
        logic signed [pam_pkg::VALUE_W-1:0] value;
        logic [pam_pkg::GAIN_W-1:0]         gain;
        logic [7:0]                         pga;
    } reading_t;

    logic                                aclk         = 1'b0;
    logic                                aresetn      = 1'b0;
    logic                                s_valid      = 1'b0;
    logic                                s_ready;
    logic                                s_func       = 1'b0;
    logic [pam_pkg::ADC_W-1:0]           s_adc_sample = '0;
    logic signed [pam_pkg::CUR_W-1:0]    s_current_ma = '0;
    logic                                m_valid;
    logic                                m_ready      = 1'b0;
    logic [1:0]                          m_status;
    logic signed [pam_pkg::VALUE_W-1:0]  m_value;
    logic [pam_pkg::GAIN_W-1:0]          m_gain_index;
    logic [7:0]                          m_pga_word;
    logic                                cfg_valid    = 1'b0;
    logic                                cfg_ready;
    logic [pam_pkg::CFG_IDX_W-1:0]       cfg_index    = '0;
    logic [pam_pkg::CFG_DATA_W-1:0]      cfg_data     = '0;

    pga_autorange_measurement i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_adc_sample (s_adc_sample),
        .s_current_ma (s_current_ma),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_value      (m_value),
        .m_gain_index (m_gain_index),
        .m_pga_word   (m_pga_word),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    sample_t  pending_samples[$];
    reading_t expected_readings[$];

    // Shadow copy of the block's registers and per-channel gain state.
    logic [7:0]                 div_ratio;
    logic [15:0]                shunt_res;
    logic [pam_pkg::GAIN_W-1:0] cur_gain;
    logic [pam_pkg::GAIN_W-1:0] volt_gain;

    int  errors         = 0;
    int  reports        = 0;
    int  cycles         = 0;
    int  samples_sent   = 0;
    int  readings_seen  = 0;
    int  cfg_writes     = 0;
    int  status_count[4] = '{0, 0, 0, 0};
    bit  calm_mode      = 1'b0;
    int  stall_requests = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d readings outstanding", cycles,
                     expected_readings.size());
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int gain_factor(input logic [pam_pkg::GAIN_W-1:0] idx);
        case (idx)
            3'd0:    return 1;
            3'd1:    return 2;
            3'd2:    return 5;
            3'd3:    return 10;
            3'd4:    return 20;
            3'd5:    return 50;
            3'd6:    return 100;
            default: return 200;
        endcase
    endfunction

    function automatic int raise_level(input logic [pam_pkg::GAIN_W-1:0] idx);
        case (idx)
            3'd0, 3'd3, 3'd6: return 480;
            3'd1, 3'd4:       return 170;
            3'd2, 3'd5:       return 70;
            default:          return 0;
        endcase
    endfunction

    // Range one sample, compute its scaled value and advance the channel's gain.
    function automatic reading_t predict_reading(input sample_t it);
        reading_t                   r;
        logic [pam_pkg::GAIN_W-1:0] g;
        int                         s;
        longint                     d, c, v, vd, sh;
        g  = it.func ? volt_gain : cur_gain;
        s  = it.sample;
        c  = $signed(it.current);
        vd = div_ratio;
        sh = shunt_res;
        if (sh == 0) sh = 1;
        v  = 0;
        r.status = pam_pkg::STATUS_VALID;
        if (it.sample > pam_pkg::OVER_LIMIT) begin
            if (g != 0) begin
                g = g - 1;
                r.status = pam_pkg::STATUS_LOWERED;
            end else begin
                r.status = pam_pkg::STATUS_OVERFLOW;
            end
        end else if (s < raise_level(g) && g != pam_pkg::GAIN_MAX) begin
            g = g + 1;
            r.status = pam_pkg::STATUS_RAISED;
        end else begin
            d = (s - 1) * 2;
            if (it.func) begin
                v = (d * 100) / gain_factor(g);
                v = v - c * 100;
                v = v * vd;
                v = v / 100;
            end else begin
                v = d * vd;
                v = v / gain_factor(g);
                v = v / sh;
                v = v / 10;
            end
        end
        if (it.func) volt_gain = g;
        else cur_gain = g;
        r.value = v[pam_pkg::VALUE_W-1:0];
        r.gain  = g;
        r.pga   = {1'b0, g, 3'b000, ~it.func};
        return r;
    endfunction

    // Follow register writes and accepted samples in the shadow model.
    always @(posedge aclk) begin
        reading_t r;
        if (!aresetn) begin
            div_ratio = 8'd1;
            shunt_res = 16'd1;
            cur_gain  = '0;
            volt_gain = '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                cfg_writes++;
                if (cfg_index == pam_pkg::REG_DIVIDER_RATIO) div_ratio = cfg_data[7:0];
                else if (cfg_index == pam_pkg::REG_SHUNT_RESISTANCE) shunt_res = cfg_data;
            end
            if (s_valid && s_ready) begin
                r = predict_reading('{func: s_func, sample: s_adc_sample,
                                      current: s_current_ma});
                status_count[r.status]++;
                samples_sent++;
                expected_readings.push_back(r);
            end
        end
    end

    function automatic int tx_pause();
        int r;
        r = $urandom_range(0, 99);
        if (calm_mode || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 15);
        return $urandom_range(40, 150);
    endfunction

    function automatic int rx_pause();
        int r;
        r = $urandom_range(0, 99);
        if (calm_mode || r < 85) return 0;
        if (r < 97) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    // Sample driver: hold the payload until the transfer, then pause or present the next one.
    always @(posedge aclk) begin
        int tx_gap;
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap = 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                void'(pending_samples.pop_front());
                tx_gap = tx_pause();
            end
            if (tx_gap > 0) begin
                tx_gap--;
                s_valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
                s_valid      <= 1'b1;
                s_func       <= pending_samples[0].func;
                s_adc_sample <= pending_samples[0].sample;
                s_current_ma <= pending_samples[0].current;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random back-pressure plus long stalls on request.
    always @(posedge aclk) begin
        int rx_gap;
        int stalls_served;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_gap = 0;
            stalls_served = 0;
        end else begin
            if (stalls_served != stall_requests) begin
                stalls_served = stall_requests;
                rx_gap = RX_STALL;
            end
            if (rx_gap > 0) begin
                rx_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                rx_gap = rx_pause();
            end
        end
    end

    // Compare each result transfer with the oldest prediction.
    always @(posedge aclk) begin
        reading_t want;
        if (aresetn && m_valid && m_ready) begin
            readings_seen++;
            if (expected_readings.size() == 0) begin
                errors++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display("unexpected reading: status %0d value %0d gain %0d pga %02h",
                             m_status, m_value, m_gain_index, m_pga_word);
                end
            end else begin
                want = expected_readings.pop_front();
                if (m_status !== want.status || m_value !== want.value ||
                    m_gain_index !== want.gain || m_pga_word !== want.pga) begin
                    errors++;
                    if (reports < MAX_REPORTS) begin
                        reports++;
                        $display("reading %0d mismatch: exp status %0d value %0d gain %0d pga %02h",
                                 readings_seen, want.status, want.value, want.gain, want.pga);
                        $display("                      got status %0d value %0d gain %0d pga %02h",
                                 m_status, m_value, m_gain_index, m_pga_word);
                    end
                end
            end
        end
    end

    task automatic push_sample(input logic f, input int s, input int c);
        sample_t it;
        it.func    = f;
        it.sample  = s[pam_pkg::ADC_W-1:0];
        it.current = c[pam_pkg::CUR_W-1:0];
        pending_samples.push_back(it);
    endtask

    task automatic write_reg(input logic [pam_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pam_pkg::CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_scaling(input logic [7:0] div, input logic [15:0] shunt);
        logic [7:0] junk;
        // Upper byte of the divider write is don't-care; fill it with noise.
        junk = $urandom_range(0, 255);
        write_reg(pam_pkg::REG_DIVIDER_RATIO, {junk, div});
        write_reg(pam_pkg::REG_SHUNT_RESISTANCE, shunt);
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || expected_readings.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic int pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return $urandom_range(1022, 1023);
        if (r < 30) return $urandom_range(0, 69);
        if (r < 45) return $urandom_range(0, 479);
        return $urandom_range(0, 1023);
    endfunction

    function automatic int pick_current();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return -65536;
        if (r < 6) return 65535;
        if (r < 50) return int'($urandom_range(0, 400)) - 200;
        return int'($urandom_range(0, 131071)) - 65536;
    endfunction

    task automatic run_phase(input logic [7:0] div, input logic [15:0] shunt, input int count,
                             input bit calm, input bit hold_rx);
        int  n;
        int  k;
        logic f;
        set_scaling(div, shunt);
        calm_mode = calm;
        if (hold_rx) stall_requests++;
        n = 0;
        while (n < count) begin
            f = $urandom_range(0, 1);
            if ($urandom_range(0, 19) == 0) begin
                // Climb the channel toward its top gain with a run of low samples.
                for (k = 0; k < 8; k++) push_sample(f, $urandom_range(0, 69), pick_current());
                n += 8;
            end else begin
                push_sample(f, pick_sample(), pick_current());
                n++;
            end
        end
        wait_drained();
        calm_mode = 1'b0;
    endtask

    initial begin
        int k;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (3) @(posedge aclk);

        // Directed: overflow, boundaries, top-gain values and extreme currents.
        set_scaling(8'd255, 16'd1);
        push_sample(1'b0, 1023, 0);
        push_sample(1'b1, 1022, 0);
        push_sample(1'b0, 480, 0);
        push_sample(1'b0, 479, 0);
        for (k = 0; k < 6; k++) push_sample(1'b0, 0, 0);
        push_sample(1'b0, 0, -1);
        push_sample(1'b0, 1021, 65535);
        push_sample(1'b0, 1022, 0);
        push_sample(1'b1, 1021, -65536);
        push_sample(1'b1, 1021, 65535);
        push_sample(1'b1, 500, -1);
        for (k = 0; k < 7; k++) push_sample(1'b1, 0, 0);
        push_sample(1'b1, 0, 12345);
        push_sample(1'b1, 1023, -65536);
        wait_drained();

        run_phase(8'd1, 16'd1, 235, 1'b0, 1'b0);
        run_phase(8'd255, 16'd65535, 235, 1'b0, 1'b0);
        run_phase(8'd0, 16'd13, 235, 1'b0, 1'b0);
        run_phase(8'd97, 16'd0, 235, 1'b1, 1'b0);
        run_phase(8'd255, 16'd1, 235, 1'b0, 1'b1);
        write_reg(REG_SPARE, 16'($urandom_range(0, 65535)));
        run_phase(8'($urandom_range(1, 255)), 16'($urandom_range(1, 65535)), 235, 1'b0, 1'b0);
        run_phase(8'd1, 16'd65535, 235, 1'b0, 1'b0);
        run_phase(8'($urandom_range(1, 255)), 16'($urandom_range(1, 9)), 235, 1'b0, 1'b0);

        if (expected_readings.size() != 0) errors += expected_readings.size();
        $display("%0d samples, %0d register writes: %0d values, %0d lowered,",
                 samples_sent, cfg_writes, status_count[pam_pkg::STATUS_VALID],
                 status_count[pam_pkg::STATUS_LOWERED]);
        $display("%0d raised, %0d overflow; %0d readings checked, %0d errors",
                 status_count[pam_pkg::STATUS_RAISED], status_count[pam_pkg::STATUS_OVERFLOW],
                 readings_seen, errors);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
